[hw/rtl/tlbpt_pkg.sv]
// Shared types and fixed field widths for the TLB and page table translator.
package tlbpt_pkg;

	localparam int ADDR_W = 16;
	localparam int PHYS_W = 15;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_LOOK  = 5'b00100,
		S_TABLE = 5'b01000,
		S_MAP   = 5'b10000
	} state_t;

endpackage

[hw/rtl/tlbpt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tlb_page_table_translator_top.sv]
// Top level of the address translator: TLB in registers, page table and frame owner map in RAM.
//
// Each transaction takes a 16-bit logical address and returns one result: the physical
// address with TLB hit and page fault flags, shown for exactly one cycle while done is high.
// The receiver cannot stall; the result register frees the block, so a new start is taken
// in the cycle the result appears. A TLB hit passes through LOOK only, a page table hit
// through LOOK and TABLE, and a page fault through LOOK, TABLE and MAP. The single write
// port of the page table is why a fault needs MAP: it must both invalidate the page that
// owned the victim frame and map the new page. After reset the page table is cleared one
// entry per cycle, and busy stays high until the clearing pass ends.
module tlb_page_table_translator_top #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_COUNT  = 256,
	parameter int FRAME_COUNT = 128,
	parameter int OFFSET_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address,
	output logic                          done,
	output logic [tlbpt_pkg::PHYS_W-1:0]  physical_address,
	output logic                          tlb_hit,
	output logic                          page_fault
);

	localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
	localparam int FRAME_BITS = $clog2(FRAME_COUNT);
	localparam int SLOT_BITS  = $clog2(TLB_ENTRIES);
	localparam int RAW_BITS   = tlbpt_pkg::ADDR_W - OFFSET_BITS;
	localparam int STEPS      = (RAW_BITS >= PAGE_BITS) ? RAW_BITS - PAGE_BITS + 1 : 0;

	tlbpt_pkg::state_t state_q;

	logic [tlbpt_pkg::ADDR_W-1:0] addr_s1;
	logic [PAGE_BITS-1:0]         page_s1;
	logic [PAGE_BITS-1:0]         page_in;

	logic [PAGE_BITS-1:0]  tlb_page_q  [TLB_ENTRIES];
	logic [FRAME_BITS-1:0] tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TLB_ENTRIES-1:0] tlb_valid_d;
	logic [SLOT_BITS-1:0]  slot_q;

	logic [FRAME_BITS-1:0] victim_q;
	logic                  wrapped_q;
	logic [PAGE_BITS-1:0]  clr_q;

	logic                  done_q;
	logic [tlbpt_pkg::PHYS_W-1:0] phys_q;
	logic                  hit_q;
	logic                  fault_q;

	logic [TLB_ENTRIES-1:0] tlb_match;
	logic                  look_hit;
	logic [FRAME_BITS-1:0] look_frame;

	logic                  tbl_we;
	logic [PAGE_BITS-1:0]  tbl_waddr;
	logic [FRAME_BITS:0]   tbl_wdata;
	logic [FRAME_BITS:0]   tbl_rdata;
	logic                  own_we;
	logic [PAGE_BITS-1:0]  own_rdata;

	logic                  accept;
	logic                  tbl_valid;
	logic                  finish;
	logic [FRAME_BITS-1:0] res_frame;
	logic [31:0]           phys_wide;

	assign accept = start && (state_q == tlbpt_pkg::S_IDLE);
	assign busy   = (state_q != tlbpt_pkg::S_IDLE);

	// Page number modulo PAGE_COUNT by restoring subtraction of shifted page counts.
	always_comb begin
		logic [31:0] r;
		r = 32'(logical_address) >> OFFSET_BITS;
		for (int k = STEPS - 1; k >= 0; k--) begin
			if (r >= (32'(PAGE_COUNT) << k)) begin
				r = r - (32'(PAGE_COUNT) << k);
			end
		end
		page_in = r[PAGE_BITS-1:0];
	end

	// Parallel TLB compare; the lowest matching entry wins.
	always_comb begin
		look_hit   = 1'b0;
		look_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			tlb_match[i] = tlb_valid_q[i] && (tlb_page_q[i] == page_s1);
			if (tlb_match[i]) begin
				look_hit   = 1'b1;
				look_frame = tlb_frame_q[i];
			end
		end
	end

	assign tbl_valid = tbl_rdata[FRAME_BITS];
	assign res_frame = (state_q == tlbpt_pkg::S_LOOK) ? look_frame :
		(state_q == tlbpt_pkg::S_MAP) ? victim_q : tbl_rdata[FRAME_BITS-1:0];
	assign finish = ((state_q == tlbpt_pkg::S_LOOK) && look_hit) ||
		((state_q == tlbpt_pkg::S_TABLE) && tbl_valid) ||
		(state_q == tlbpt_pkg::S_MAP);

	assign phys_wide = (32'(res_frame) << OFFSET_BITS) |
		(32'(addr_s1) & ((32'd1 << OFFSET_BITS) - 32'd1));

	// On a TLB miss, drop entries holding the frame, then fill the FIFO slot.
	always_comb begin
		tlb_valid_d = tlb_valid_q;
		if (finish && (state_q != tlbpt_pkg::S_LOOK)) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (tlb_frame_q[i] == res_frame) begin
					tlb_valid_d[i] = 1'b0;
				end
			end
			tlb_valid_d[slot_q] = 1'b1;
		end
	end

	// Page table write port: clearing pass, invalidation of the old owner, then the new mapping.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = page_s1;
		tbl_wdata = {1'b1, victim_q};
		own_we    = 1'b0;
		case (state_q)
			tlbpt_pkg::S_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
			end
			tlbpt_pkg::S_TABLE: begin
				if (!tbl_valid) begin
					// The victim frame has an owner only once every frame has been handed out.
					tbl_we    = wrapped_q;
					tbl_waddr = own_rdata;
					tbl_wdata = '0;
					own_we    = 1'b1;
				end
			end
			tlbpt_pkg::S_MAP: begin
				tbl_we = 1'b1;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	tlbpt_ram #(
		.WIDTH(FRAME_BITS + 1),
		.DEPTH(PAGE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(page_s1),
		.rdata(tbl_rdata)
	);

	tlbpt_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(FRAME_COUNT)
	) u_owner (
		.clk  (clk),
		.we   (own_we),
		.waddr(victim_q),
		.wdata(page_s1),
		.raddr(victim_q),
		.rdata(own_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlbpt_pkg::S_CLEAR;
			clr_q       <= '0;
			tlb_valid_q <= '0;
			slot_q      <= '0;
			victim_q    <= '0;
			wrapped_q   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= finish;
			tlb_valid_q <= tlb_valid_d;
			case (state_q)
				tlbpt_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PAGE_BITS'(PAGE_COUNT - 1)) begin
						state_q <= tlbpt_pkg::S_IDLE;
					end
				end
				tlbpt_pkg::S_IDLE: begin
					if (start) begin
						state_q <= tlbpt_pkg::S_LOOK;
					end
				end
				tlbpt_pkg::S_LOOK: begin
					state_q <= look_hit ? tlbpt_pkg::S_IDLE : tlbpt_pkg::S_TABLE;
				end
				tlbpt_pkg::S_TABLE: begin
					state_q <= tbl_valid ? tlbpt_pkg::S_IDLE : tlbpt_pkg::S_MAP;
				end
				tlbpt_pkg::S_MAP: begin
					state_q <= tlbpt_pkg::S_IDLE;
					if (victim_q == FRAME_BITS'(FRAME_COUNT - 1)) begin
						victim_q  <= '0;
						wrapped_q <= 1'b1;
					end else begin
						victim_q <= victim_q + 1'b1;
					end
				end
				default: begin
					state_q <= tlbpt_pkg::S_IDLE;
				end
			endcase
			if (finish && (state_q != tlbpt_pkg::S_LOOK)) begin
				if (slot_q == SLOT_BITS'(TLB_ENTRIES - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= logical_address;
			page_s1 <= page_in;
		end
		if (finish && (state_q != tlbpt_pkg::S_LOOK)) begin
			tlb_page_q[slot_q]  <= page_s1;
			tlb_frame_q[slot_q] <= res_frame;
		end
		if (finish) begin
			phys_q  <= phys_wide[tlbpt_pkg::PHYS_W-1:0];
			hit_q   <= (state_q == tlbpt_pkg::S_LOOK);
			fault_q <= (state_q == tlbpt_pkg::S_MAP);
		end
	end

	assign done             = done_q;
	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == tlbpt_pkg::S_LOOK || state_q == tlbpt_pkg::S_TABLE ||
			state_q == tlbpt_pkg::S_MAP))
		else $error("result strobe without a transaction in flight");

	a_fault_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(tlb_hit && page_fault))
		else $error("result flags both TLB hit and page fault");

	a_tlb_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlbpt_pkg::S_LOOK) |-> $onehot0(tlb_match))
		else $error("more than one valid TLB entry matches the page");

	a_no_start_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlbpt_pkg::S_CLEAR) |=> (state_q == tlbpt_pkg::S_CLEAR ||
			state_q == tlbpt_pkg::S_IDLE))
		else $error("transaction started during the page table clearing pass");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the TLB and page table address translator.
`timescale 1ns / 1ps
module testbench;

	localparam int ADDR_W       = tlbpt_pkg::ADDR_W;
	localparam int PHYS_W       = tlbpt_pkg::PHYS_W;
	localparam int TLB_ENTRIES  = 16;
	localparam int PAGE_COUNT   = 256;
	localparam int FRAME_COUNT  = 128;
	localparam int OFFSET_BITS  = 8;
	localparam int PAGE_W       = 8;
	localparam int FRAME_W      = 7;
	localparam int SLOT_W       = 4;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 17;
	localparam int DIRECTED_ROWS = 21;

	typedef struct packed {
		logic [PHYS_W-1:0] physical_address;
		logic              tlb_hit;
		logic              page_fault;
	} translation_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              known;
		translation_t      result;
	} stimulus_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ADDR_W-1:0]   logical_address;
	logic                done;
	logic [PHYS_W-1:0]   physical_address;
	logic                tlb_hit;
	logic                page_fault;

	// Shadow copy of the translation state.
	logic [PAGE_W-1:0]   shadow_tlb_page  [TLB_ENTRIES];
	logic [FRAME_W-1:0]  shadow_tlb_frame [TLB_ENTRIES];
	logic                shadow_tlb_valid [TLB_ENTRIES];
	logic [FRAME_W-1:0]  shadow_page_frame [PAGE_COUNT];
	logic                shadow_page_valid [PAGE_COUNT];
	logic [FRAME_W-1:0]  victim_frame;
	logic [SLOT_W-1:0]   tlb_slot;

	translation_t pending_translations[$];
	int    error_count = 0;
	int    translated_count = 0;
	int    tlb_hit_count = 0;
	int    page_table_hit_count = 0;
	int    page_fault_count = 0;
	int    frame_wrap_count = 0;
	longint cycle_count = 0;

	// Rows with a typed result can be read straight off the translation rules;
	// the rest are checked against the shadow model.
	stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'h0000, 1'b1, '{15'h0000, 1'b0, 1'b1}},
		'{16'h00FF, 1'b1, '{15'h00FF, 1'b1, 1'b0}},
		'{16'hFFFF, 1'b1, '{15'h01FF, 1'b0, 1'b1}},
		'{16'hFF00, 1'b1, '{15'h0100, 1'b1, 1'b0}},
		'{16'h8055, 1'b1, '{15'h0255, 1'b0, 1'b1}},
		'{16'h0123, 1'b1, '{15'h0323, 1'b0, 1'b1}},
		'{16'h1000, 1'b0, '0},
		'{16'h1111, 1'b0, '0},
		'{16'h1222, 1'b0, '0},
		'{16'h1333, 1'b0, '0},
		'{16'h1444, 1'b0, '0},
		'{16'h1555, 1'b0, '0},
		'{16'h16AA, 1'b0, '0},
		'{16'h1777, 1'b0, '0},
		'{16'h1888, 1'b0, '0},
		'{16'h1999, 1'b0, '0},
		'{16'h1AAA, 1'b0, '0},
		'{16'h1BBB, 1'b0, '0},
		'{16'h1CFF, 1'b0, '0},
		'{16'h0042, 1'b0, '0},
		'{16'h7FAA, 1'b0, '0}
	};

	tlb_page_table_translator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.logical_address  (logical_address),
		.done             (done),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic translation_t translate(input logic [ADDR_W-1:0] address);
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		translation_t       r;
		page = address[ADDR_W-1:OFFSET_BITS];
		frame = '0;
		r = '0;
		// Lowest valid matching TLB entry wins.
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!r.tlb_hit && shadow_tlb_valid[i] && shadow_tlb_page[i] == page) begin
				frame = shadow_tlb_frame[i];
				r.tlb_hit = 1'b1;
			end
		end
		if (!r.tlb_hit) begin
			if (shadow_page_valid[page]) begin
				frame = shadow_page_frame[page];
				page_table_hit_count++;
			end else begin
				r.page_fault = 1'b1;
				frame = victim_frame;
				for (int i = 0; i < PAGE_COUNT; i++)
					if (shadow_page_frame[i] == frame)
						shadow_page_valid[i] = 1'b0;
				shadow_page_frame[page] = frame;
				shadow_page_valid[page] = 1'b1;
				victim_frame = FRAME_W'((int'(frame) + 1) % FRAME_COUNT);
				if (victim_frame == '0)
					frame_wrap_count++;
				page_fault_count++;
			end
			for (int i = 0; i < TLB_ENTRIES; i++)
				if (shadow_tlb_frame[i] == frame)
					shadow_tlb_valid[i] = 1'b0;
			shadow_tlb_page[tlb_slot] = page;
			shadow_tlb_frame[tlb_slot] = frame;
			shadow_tlb_valid[tlb_slot] = 1'b1;
			tlb_slot = SLOT_W'((int'(tlb_slot) + 1) % TLB_ENTRIES);
		end else begin
			tlb_hit_count++;
		end
		translated_count++;
		r.physical_address = {frame, address[OFFSET_BITS-1:0]};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// Enters and leaves at a falling edge; start stays high for a following transaction.
	task automatic issue_address(input logic [ADDR_W-1:0] address, input int gap,
			input logic known, input translation_t typed_result);
		translation_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			logical_address <= ADDR_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		logical_address <= address;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = translate(address);
		pending_translations.push_back(known ? typed_result : predicted);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		translation_t want;
		if (arst_n && done) begin
			if (pending_translations.size() == 0) begin
				report_mismatch("result with no transaction outstanding, address",
					physical_address, 0);
			end else begin
				want = pending_translations.pop_front();
				if (physical_address !== want.physical_address)
					report_mismatch("physical_address", physical_address, want.physical_address);
				if (tlb_hit !== want.tlb_hit)
					report_mismatch("tlb_hit", tlb_hit, want.tlb_hit);
				if (page_fault !== want.page_fault)
					report_mismatch("page_fault", page_fault, want.page_fault);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_translations.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int             set_base;
		int             set_size;
		int             pick;
		int             gap;
		logic [PAGE_W-1:0] page;
		start = 1'b0;
		logical_address = '0;
		arst_n = 1'b0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			shadow_tlb_page[i] = '0;
			shadow_tlb_frame[i] = '0;
			shadow_tlb_valid[i] = 1'b0;
		end
		for (int i = 0; i < PAGE_COUNT; i++) begin
			shadow_page_frame[i] = '0;
			shadow_page_valid[i] = 1'b0;
		end
		victim_frame = '0;
		tlb_slot = '0;
		set_base = 0;
		set_size = 1;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			gap = ($urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 6) : 0;
			issue_address(directed_rows[i].address, gap, directed_rows[i].known,
				directed_rows[i].result);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Every so often move to a new working set: small sets stay in the TLB,
			// medium ones live in the page table, large ones keep faulting.
			if (n % 64 == 0) begin
				pick = $urandom_range(0, 9);
				set_base = $urandom_range(0, PAGE_COUNT - 1);
				if (pick < 4)
					set_size = $urandom_range(2, 12);
				else if (pick < 7)
					set_size = $urandom_range(17, 90);
				else
					set_size = $urandom_range(FRAME_COUNT + 1, PAGE_COUNT);
			end
			if ($urandom_range(0, 99) < 8)
				page = PAGE_W'($urandom);
			else
				page = PAGE_W'((set_base + $urandom_range(0, set_size - 1)) % PAGE_COUNT);
			if (n >= 800 && n < 1200)
				gap = 0;
			else
				gap = ($urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 6) : 0;
			issue_address({page, OFFSET_BITS'($urandom)}, gap, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_translations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d translations: %0d TLB hits, %0d page table hits, %0d page faults.",
			translated_count, tlb_hit_count, page_table_hit_count, page_fault_count);
		$display("Frame pool wrapped %0d times; %0d mismatches seen.",
			frame_wrap_count, error_count);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
